>>> hw/rtl/assert_macros.svh
// Assertion helpers for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication, disabled during reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/nkro6_pkg.sv
// ----------------------------------------------------------------------------
// nkro6_pkg
// Shared constants and types of the NKRO to six-slot report converter.
// ----------------------------------------------------------------------------
`default_nettype none

package nkro6_pkg;

  localparam int NKRO_BYTES     = 32;
  localparam int KEY_SLOTS      = 6;
  localparam int OVERFLOW_BYTES = 16;
  localparam int OVF_SENT       = (OVERFLOW_BYTES < 16) ? OVERFLOW_BYTES : 16;

  localparam int BM_AW  = (NKRO_BYTES > 1) ? $clog2(NKRO_BYTES) : 1;
  localparam int OV_AW  = (OVERFLOW_BYTES > 1) ? $clog2(OVERFLOW_BYTES) : 1;
  localparam int CNT_W  = $clog2(NKRO_BYTES + 1) + 1;
  localparam int SLOT_W = 3;

  localparam logic [3:0] OVF_LAST_IDX = 4'(OVF_SENT - 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_REL_RD   = 8'b0000_0010,
    ST_REL_CHK  = 8'b0000_0100,
    ST_PL_RD    = 8'b0000_1000,
    ST_PL_BIT   = 8'b0001_0000,
    ST_EMIT_KB  = 8'b0010_0000,
    ST_OVF_RD   = 8'b0100_0000,
    ST_OVF_EMIT = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/nkro6_ram.sv
// ----------------------------------------------------------------------------
// nkro6_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nkro6_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/nkro_to_sticky_six_slot_report.sv
// ----------------------------------------------------------------------------
// nkro_to_sticky_six_slot_report
// NKRO bitmap to sticky six-slot boot keyboard report, with overflow bitmap.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | sink      | in_valid/in_stall  | kind mods bitmap_byte last link_up
//  out     | source    | out_valid/out_stall| record_type out_mods key_slot_0..5
//          |           |                    | overflow_index overflow_byte
//          |           |                    | last_of_run
//
// Steps: a bitmap byte that is not last is stored in IDLE. A last byte with the
//   link up runs the release pass (REL_RD and REL_CHK for each slot, one bitmap
//   RAM read per slot), the placement walk (PL_RD, then PL_BIT for each bit of
//   each received byte, one bit per cycle), the keyboard report (EMIT_KB), and
//   OVF_RD and OVF_EMIT for each overflow byte when overflow is sent.
// Reset clears slots, byte count and control; RAM contents need no clearing.
// Output stalls hold the result register; in_stall is high while converting.
//
`default_nettype none

module nkro_to_sticky_six_slot_report (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] mods,
  input  wire logic [7:0] bitmap_byte,
  input  wire logic       last,
  input  wire logic       link_up,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            record_type,
  output logic [7:0]      out_mods,
  output logic [7:0]      key_slot_0,
  output logic [7:0]      key_slot_1,
  output logic [7:0]      key_slot_2,
  output logic [7:0]      key_slot_3,
  output logic [7:0]      key_slot_4,
  output logic [7:0]      key_slot_5,
  output logic [3:0]      overflow_index,
  output logic [7:0]      overflow_byte,
  output logic            last_of_run
);

  nkro6_pkg::state_t state;

  logic [7:0]                    slot_keys [nkro6_pkg::KEY_SLOTS];
  logic [7:0]                    out_slots [nkro6_pkg::KEY_SLOTS];
  logic [nkro6_pkg::CNT_W-1:0]   byte_count;
  logic [nkro6_pkg::CNT_W-1:0]   bidx;       // placement byte index
  logic [2:0]                    bit_pos;    // placement bit, 7 down to 0
  logic [nkro6_pkg::SLOT_W-1:0]  sidx;       // release slot index
  logic [3:0]                    oidx;       // overflow send index
  logic [7:0]                    mods_hold;
  logic [7:0]                    ovf_acc;
  logic                          ovf_any;

  // bitmap RAM
  logic                          bm_we;
  logic [nkro6_pkg::BM_AW-1:0]   bm_waddr;
  logic [nkro6_pkg::BM_AW-1:0]   bm_raddr;
  logic [7:0]                    bm_rdata;

  // overflow RAM
  logic                          ov_we;
  logic [nkro6_pkg::OV_AW-1:0]   ov_waddr;
  logic [nkro6_pkg::OV_AW-1:0]   ov_raddr;
  logic [7:0]                    ov_rdata;

  logic                          in_xfer;
  logic                          out_free;
  logic                          out_valid_next;
  logic [7:0]                    rel_key;
  logic                          rel_down;
  logic [7:0]                    usage;
  logic                          cand;
  logic                          present;
  logic                          has_free;
  logic [nkro6_pkg::SLOT_W-1:0]  free_slot;
  logic                          ovf_ok;
  logic [7:0]                    ovf_acc_next;
  logic                          byte_done;
  logic                          walk_done;

  assign in_stall = (state != nkro6_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // result register loads in the emit states, otherwise holds until taken
  assign out_valid_next = ((state == nkro6_pkg::ST_EMIT_KB || state == nkro6_pkg::ST_OVF_EMIT)
                           && out_free) ? 1'b1 : (out_valid && out_stall);

  // store bitmap bytes while they arrive; extra bytes are ignored
  assign bm_we    = in_xfer && !kind && (byte_count < nkro6_pkg::CNT_W'(nkro6_pkg::NKRO_BYTES));
  assign bm_waddr = nkro6_pkg::BM_AW'(byte_count);

  // release pass reads the byte of each slotted key; walk reads bytes in order
  assign rel_key  = slot_keys[sidx];
  assign bm_raddr = (state == nkro6_pkg::ST_REL_RD || state == nkro6_pkg::ST_REL_CHK)
                    ? nkro6_pkg::BM_AW'(rel_key[7:3])
                    : nkro6_pkg::BM_AW'(bidx);
  assign rel_down = (nkro6_pkg::CNT_W'(rel_key[7:3]) < byte_count) && bm_rdata[rel_key[2:0]];

  // placement of one bit
  assign usage = 8'({bidx, bit_pos});
  assign cand  = bm_rdata[bit_pos] && (usage != 8'h00);

  always_comb begin
    present   = 1'b0;
    has_free  = 1'b0;
    free_slot = '0;
    for (int s = nkro6_pkg::KEY_SLOTS - 1; s >= 0; s--) begin
      if (slot_keys[s] == usage) begin
        present = 1'b1;
      end
      if (slot_keys[s] == 8'h00) begin
        has_free  = 1'b1;
        free_slot = nkro6_pkg::SLOT_W'(s);
      end
    end
  end

  assign ovf_ok       = bidx < nkro6_pkg::CNT_W'(nkro6_pkg::OVF_SENT);
  assign ovf_acc_next = (cand && !present && !has_free && ovf_ok)
                        ? (ovf_acc | (8'h01 << bit_pos)) : ovf_acc;
  assign byte_done    = (bit_pos == 3'd0);
  assign walk_done    = (bidx + nkro6_pkg::CNT_W'(1)) == byte_count;

  assign ov_we    = (state == nkro6_pkg::ST_PL_BIT) && byte_done && ovf_ok;
  assign ov_waddr = nkro6_pkg::OV_AW'(bidx);
  assign ov_raddr = nkro6_pkg::OV_AW'(oidx);

  nkro6_ram #(.WIDTH(8), .DEPTH(nkro6_pkg::NKRO_BYTES)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bitmap_byte),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  nkro6_ram #(.WIDTH(8), .DEPTH(nkro6_pkg::OVERFLOW_BYTES)) u_ovf_ram (
    .clk   (clk),
    .we    (ov_we),
    .waddr (ov_waddr),
    .wdata (ovf_acc_next),
    .raddr (ov_raddr),
    .rdata (ov_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nkro6_pkg::ST_IDLE;
      byte_count <= '0;
      out_valid  <= 1'b0;
      for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++) begin
        slot_keys[s] <= 8'h00;
      end
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        nkro6_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (kind) begin
              byte_count <= '0;
              if (link_up) begin
                for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++) begin
                  slot_keys[s] <= 8'h00;
                end
                mods_hold <= 8'h00;
                ovf_any   <= 1'b0;
                state     <= nkro6_pkg::ST_EMIT_KB;
              end
            end else begin
              // link down on the last byte drops the report
              if (last && !link_up) begin
                byte_count <= '0;
              end else if (bm_we) begin
                byte_count <= byte_count + nkro6_pkg::CNT_W'(1);
              end
              if (last && link_up) begin
                mods_hold <= mods;
                sidx      <= '0;
                state     <= nkro6_pkg::ST_REL_RD;
              end
            end
          end
        end
        nkro6_pkg::ST_REL_RD: begin
          state <= nkro6_pkg::ST_REL_CHK;
        end
        nkro6_pkg::ST_REL_CHK: begin
          if (rel_key != 8'h00 && !rel_down) begin
            slot_keys[sidx] <= 8'h00;
          end
          if (sidx == nkro6_pkg::SLOT_W'(nkro6_pkg::KEY_SLOTS - 1)) begin
            bidx    <= '0;
            ovf_any <= 1'b0;
            state   <= nkro6_pkg::ST_PL_RD;
          end else begin
            sidx  <= sidx + nkro6_pkg::SLOT_W'(1);
            state <= nkro6_pkg::ST_REL_RD;
          end
        end
        nkro6_pkg::ST_PL_RD: begin
          bit_pos <= 3'd7;
          ovf_acc <= 8'h00;
          state   <= nkro6_pkg::ST_PL_BIT;
        end
        nkro6_pkg::ST_PL_BIT: begin
          if (cand && !present && has_free) begin
            slot_keys[free_slot] <= usage;
          end
          ovf_acc <= ovf_acc_next;
          if (byte_done) begin
            if (ovf_acc_next != 8'h00) begin
              ovf_any <= 1'b1;
            end
            bidx <= bidx + nkro6_pkg::CNT_W'(1);
            state <= walk_done ? nkro6_pkg::ST_EMIT_KB : nkro6_pkg::ST_PL_RD;
          end else begin
            bit_pos <= bit_pos - 3'd1;
          end
        end
        nkro6_pkg::ST_EMIT_KB: begin
          if (out_free) begin
            record_type    <= 1'b0;
            out_mods       <= mods_hold;
            for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++) begin
              out_slots[s] <= slot_keys[s];
            end
            overflow_index <= 4'd0;
            overflow_byte  <= 8'h00;
            last_of_run    <= !ovf_any;
            oidx           <= 4'd0;
            if (ovf_any) begin
              state <= nkro6_pkg::ST_OVF_RD;
            end else begin
              byte_count <= '0;
              state      <= nkro6_pkg::ST_IDLE;
            end
          end
        end
        nkro6_pkg::ST_OVF_RD: begin
          state <= nkro6_pkg::ST_OVF_EMIT;
        end
        nkro6_pkg::ST_OVF_EMIT: begin
          if (out_free) begin
            record_type    <= 1'b1;
            out_mods       <= 8'h00;
            for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++) begin
              out_slots[s] <= 8'h00;
            end
            overflow_index <= oidx;
            // bytes past the received count were not written this report
            overflow_byte  <= (nkro6_pkg::CNT_W'(oidx) < byte_count) ? ov_rdata : 8'h00;
            last_of_run    <= (oidx == nkro6_pkg::OVF_LAST_IDX);
            if (oidx == nkro6_pkg::OVF_LAST_IDX) begin
              byte_count <= '0;
              state      <= nkro6_pkg::ST_IDLE;
            end else begin
              oidx  <= oidx + 4'd1;
              state <= nkro6_pkg::ST_OVF_RD;
            end
          end
        end
        default: begin
          state <= nkro6_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign key_slot_0 = out_slots[0];
  assign key_slot_1 = out_slots[1];
  assign key_slot_2 = out_slots[2];
  assign key_slot_3 = out_slots[3];
  assign key_slot_4 = out_slots[4];
  assign key_slot_5 = out_slots[5];

endmodule

`default_nettype wire

>>> hw/rtl/nkro6_checker.sv
// ----------------------------------------------------------------------------
// nkro6_checker
// Port-level checks of the six-slot report converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nkro6_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       record_type,
  input wire logic [7:0] out_mods,
  input wire logic [7:0] key_slot_0,
  input wire logic [3:0] overflow_index,
  input wire logic [7:0] overflow_byte,
  input wire logic       last_of_run
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(overflow_byte) && $stable(key_slot_0), "stalled result changed")
  `ASSERT_IMP(a_ovf_clean, clk, rst, out_valid && record_type, out_mods == 8'h00 && key_slot_0 == 8'h00, "overflow record carries report data")
  `ASSERT_IMP(a_kb_clean, clk, rst, out_valid && !record_type, overflow_index == 4'd0 && overflow_byte == 8'h00, "keyboard report carries overflow data")
  `ASSERT_IMP(a_ovf_last, clk, rst, out_valid && record_type, last_of_run == (overflow_index == nkro6_pkg::OVF_LAST_IDX), "overflow run end misplaced")

endmodule

bind nkro_to_sticky_six_slot_report nkro6_checker u_nkro6_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .record_type    (record_type),
  .out_mods       (out_mods),
  .key_slot_0     (key_slot_0),
  .overflow_index (overflow_index),
  .overflow_byte  (overflow_byte),
  .last_of_run    (last_of_run)
);

`default_nettype wire

>>> verif/nkro_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nkro_report_checker
// Watches both channels of the converter, keeps its own copy of the slot
// state and the received bitmap, predicts every report and overflow record,
// and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module nkro_report_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       kind,
  input  logic [7:0] mods,
  input  logic [7:0] bitmap_byte,
  input  logic       last,
  input  logic       link_up,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       record_type,
  input  logic [7:0] out_mods,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  input  logic [3:0] overflow_index,
  input  logic [7:0] overflow_byte,
  input  logic       last_of_run,
  output int         errors,
  output int         pending
);

  typedef struct {
    logic       rtype;
    logic [7:0] mods;
    logic [7:0] keys [nkro6_pkg::KEY_SLOTS];
    logic [3:0] oidx;
    logic [7:0] obyte;
    logic       lastr;
  } record_t;

  record_t    expected_records [$];
  logic [7:0] held_slots [nkro6_pkg::KEY_SLOTS];
  logic [7:0] rx_bitmap [nkro6_pkg::NKRO_BYTES];
  int         rx_count;

  function automatic record_t blank_record();
    record_t r;
    r.rtype = 1'b0;
    r.mods  = 8'd0;
    foreach (r.keys[s]) r.keys[s] = 8'd0;
    r.oidx  = 4'd0;
    r.obyte = 8'd0;
    r.lastr = 1'b1;
    return r;
  endfunction

  function automatic bit usage_pressed(logic [7:0] u);
    int b;
    b = u >> 3;
    return (b < rx_count) && rx_bitmap[b][u[2:0]];
  endfunction

  // Release pass, then placement in extraction order, then overflow records.
  task automatic build_report(logic [7:0] m);
    logic [7:0] ovf [16];
    record_t    r;
    bit         any, present;
    int         free_slot, u;
    foreach (ovf[i]) ovf[i] = 8'd0;
    any = 0;
    for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++)
      if (held_slots[s] != 0 && !usage_pressed(held_slots[s])) held_slots[s] = 8'd0;
    for (int b = 0; b < rx_count; b++) begin
      for (int bit_i = 7; bit_i >= 0; bit_i--) begin
        u = b * 8 + bit_i;
        if (!rx_bitmap[b][bit_i] || u == 0) continue;
        present = 0;
        free_slot = -1;
        for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++) begin
          if (held_slots[s] == u[7:0]) present = 1;
          else if (held_slots[s] == 0 && free_slot < 0) free_slot = s;
        end
        if (present) continue;
        if (free_slot >= 0) held_slots[free_slot] = u[7:0];
        else if (u < nkro6_pkg::OVF_SENT * 8) ovf[u >> 3][u & 7] = 1'b1;
      end
    end
    for (int i = 0; i < nkro6_pkg::OVF_SENT; i++) if (ovf[i] != 0) any = 1;
    r = blank_record();
    r.mods = m;
    foreach (r.keys[s]) r.keys[s] = held_slots[s];
    r.lastr = !any;
    expected_records.push_back(r);
    if (any) begin
      for (int i = 0; i < nkro6_pkg::OVF_SENT; i++) begin
        r = blank_record();
        r.rtype = 1'b1;
        r.oidx  = i[3:0];
        r.obyte = ovf[i];
        r.lastr = (i == nkro6_pkg::OVF_SENT - 1);
        expected_records.push_back(r);
      end
    end
  endtask

  task automatic take_item();
    record_t r;
    if (kind) begin
      rx_count = 0;
      if (link_up) begin
        foreach (held_slots[s]) held_slots[s] = 8'd0;
        r = blank_record();
        expected_records.push_back(r);
      end
    end else begin
      if (rx_count < nkro6_pkg::NKRO_BYTES) begin
        rx_bitmap[rx_count] = bitmap_byte;
        rx_count++;
      end
      if (last) begin
        if (link_up) build_report(mods);
        rx_count = 0;
      end
    end
  endtask

  task automatic field_check(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_record();
    record_t    r;
    logic [7:0] got_keys [nkro6_pkg::KEY_SLOTS];
    got_keys = '{key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5};
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected output transfer", $time);
      errors++;
      return;
    end
    r = expected_records.pop_front();
    field_check("record_type", r.rtype, record_type);
    field_check("out_mods", r.mods, out_mods);
    for (int s = 0; s < nkro6_pkg::KEY_SLOTS; s++)
      field_check($sformatf("key_slot_%0d", s), r.keys[s], got_keys[s]);
    field_check("overflow_index", r.oidx, overflow_index);
    field_check("overflow_byte", r.obyte, overflow_byte);
    field_check("last_of_run", r.lastr, last_of_run);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (held_slots[s]) held_slots[s] = 8'd0;
      rx_count = 0;
    end else begin
      if (in_valid && !in_stall) take_item();
      if (out_valid && !out_stall) check_record();
    end
    pending = expected_records.size();
  end

endmodule

>>> verif/nkro_to_sticky_six_slot_report_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nkro_to_sticky_six_slot_report_test
// Drives bitmap reports and empty reports into the converter with random
// gaps and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module nkro_to_sticky_six_slot_report_test;

  localparam int WATCHDOG_LIMIT = 20000; // idle cycles with no transfer at all
  localparam int LONG_HOLD      = 800;   // receiver hold-off, fills the block
  localparam int RANDOM_ITEMS   = 500;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = 1'b0;
  logic [7:0] mods = 8'd0;
  logic [7:0] bitmap_byte = 8'd0;
  logic       last = 1'b0;
  logic       link_up = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic       record_type;
  logic [7:0] out_mods;
  logic [7:0] key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5;
  logic [3:0] overflow_index;
  logic [7:0] overflow_byte;
  logic       last_of_run;

  int  errors;
  int  pending;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  no_gaps = 0;      // phases with no idling on either side
  bit  hold_request = 0; // asks the receiver for one long hold-off
  bit  hold_done = 0;
  bit  drain_done = 0;

  // Keys held down across random reports; sticky slots need overlap.
  logic [7:0] held_keys [34];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nkro_to_sticky_six_slot_report uut (.*);

  nkro_report_checker checker_i (.*);

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall before each transfer, one long hold-off on request.
  initial begin : receiver
    int n;
    @(negedge rst);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 14);
      if (hold_request) begin
        hold_request = 0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input transfer; valid stays high when there is no gap.
  task automatic send_item(logic k, logic [7:0] m, logic [7:0] b, logic l, logic lk);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    mods        <= m;
    bitmap_byte <= b;
    last        <= l;
    link_up     <= lk;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_report(int nbytes, logic [7:0] m, logic lk, bit dense);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = (dense || $urandom_range(0, 3) == 0) ? 8'($urandom) : held_keys[i];
      send_item(1'b0, m, b, i == nbytes - 1, lk);
    end
  endtask

  initial begin : stimulus
    int n;
    foreach (held_keys[i]) held_keys[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reports, usage zero, overflow, release, link down.
    send_item(1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1);       // empty, link up
    send_item(1'b1, 8'h00, 8'h00, 1'b0, 1'b0);       // empty, link down
    send_item(1'b0, 8'hFF, 8'h01, 1'b1, 1'b1);       // usage zero only
    send_item(1'b0, 8'h00, 8'hFF, 1'b0, 1'b1);       // all bits: overflow
    send_item(1'b0, 8'h00, 8'hFF, 1'b0, 1'b1);
    send_item(1'b0, 8'hA5, 8'hFF, 1'b1, 1'b1);
    send_item(1'b0, 8'h5A, 8'h00, 1'b0, 1'b1);       // short report, earlier keys released
    send_item(1'b0, 8'h5A, 8'h81, 1'b1, 1'b1);
    send_item(1'b0, 8'h00, 8'h00, 1'b1, 1'b0);       // link down, no result
    send_item(1'b0, 8'h3C, 8'h00, 1'b1, 1'b1);       // everything released
    send_item(1'b1, 8'h12, 8'h34, 1'b1, 1'b1);
    send_report(17, 8'hC3, 1'b1, 1);                 // overflow near the top index
    in_valid <= 1'b0;
    wait (pending == 0);

    // Random part; most reports short, a few near or past the byte limit.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent % 120 < 20) no_gaps = 1;
      else no_gaps = 0;
      if (items_sent > 150 && !hold_done) begin
        hold_request = 1;
        hold_done    = 1;
      end
      if (items_sent > 300 && !drain_done) begin
        drain_done = 1;
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      for (int t = 0; t < 2; t++) held_keys[$urandom_range(0, 5)][$urandom_range(0, 7)] ^= 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        send_item(1'b1, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom_range(0, 3) != 0));
      end else begin
        case ($urandom_range(0, 29))
          0:       n = $urandom_range(30, 34);
          1, 2:    n = $urandom_range(5, 16);
          default: n = $urandom_range(1, 6);
        endcase
        send_report(n, 8'($urandom), $urandom_range(0, 11) != 0, $urandom_range(0, 4) == 0);
      end
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
